// File: src/scms_pkg.sv
// ----------------------------------------------------------------------------
// scms_pkg: shared types and constants of the soft circle mask stamper
// request codes, channel codes and pixel geometry
// ----------------------------------------------------------------------------
`default_nettype none
package scms_pkg;
  localparam int unsigned MaskSizeDefault = 256;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_STAMP = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } channel_e;
endpackage
`default_nettype wire

// File: src/soft_circle_mask_stamper_core.sv
// ----------------------------------------------------------------------------
// soft_circle_mask_stamper_core: soft circle stamp into an rgb mask
// keeps a square rgb mask in ram, stamps soft circles by max blend, reads back
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_axis   | in  | tuser: req_type
//          |     | tdata: center_x, center_y, hard_radius, outer_radius,
//          |     |        channel, read_x, read_y
// m_axis   | out | tdata: pixel_red, pixel_green, pixel_blue
//
// one request at a time; the sequencer walks pixels through one ram port
// clear: 2^(2*clog2(MASK_SIZE)) ram writes, one write a cycle
// stamp: box pixels outside the outer radius are skipped; inside, a ram read, then
//        the write when hard >= outer, else the sqrt (17 steps) first, and the
//        9-step divide when it runs too; box up to (2R+1)^2 pixels, then the result
// read: a ram read, then the result; unknown request or channel: the result only
// after reset a clearing pass over all 2^(2*clog2(MASK_SIZE)) words runs before the
// first request is taken; input is not ready while a result waits in m_axis
// ----------------------------------------------------------------------------
`default_nettype none
module soft_circle_mask_stamper_core #(
  parameter int unsigned MaskSize = scms_pkg::MaskSizeDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // center_x[7:0] center_y[15:8] hard_radius[23:16] outer_radius[31:24]
  // channel[33:32] read_x[41:34] read_y[49:42]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_red[7:0] pixel_green[15:8] pixel_blue[23:16]
  output logic      [23:0] m_axis_tdata
);
  import scms_pkg::*;

  localparam int unsigned CoordW = $clog2(MaskSize);
  localparam int unsigned AddrW  = 2 * CoordW;
  localparam int unsigned Depth  = 1 << AddrW;
  localparam int unsigned CW     = (CoordW > 8) ? CoordW + 1 : 9;
  localparam int unsigned BW     = CW + 1;

  typedef enum logic [10:0] {
    ST_INIT  = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_CLEAR = 11'b00000000100,
    ST_PIX   = 11'b00000001000,
    ST_RD    = 11'b00000010000,
    ST_SQRT  = 11'b00000100000,
    ST_EVAL  = 11'b00001000000,
    ST_DIV   = 11'b00010000000,
    ST_WR    = 11'b00100000000,
    ST_READ  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // request fields
  wire logic [1:0] f_req   = s_axis_tuser;
  wire logic [7:0] f_cx    = s_axis_tdata[7:0];
  wire logic [7:0] f_cy    = s_axis_tdata[15:8];
  wire logic [7:0] f_hard  = s_axis_tdata[23:16];
  wire logic [7:0] f_outer = s_axis_tdata[31:24];
  wire logic [1:0] f_ch    = s_axis_tdata[33:32];
  wire logic [7:0] f_rx    = s_axis_tdata[41:34];
  wire logic [7:0] f_ry    = s_axis_tdata[49:42];

  logic [CoordW-1:0] cx_q, cy_q, x_q, y_q, x0_q, x1_q, y1_q;
  logic [7:0]        hard_q, outer_q;
  logic [1:0]        ch_q;
  logic              rd_ok_q;
  // remembers that the current request is a read
  logic              f_read_q;
  logic [AddrW:0]    cnt_q;
  logic [16:0]       d2_q;
  // sqrt: 34-bit radicand d2<<16, partial root kept at full width
  logic [33:0]       rem_q;
  logic [33:0]       root_q;
  logic [33:0]       sbit_q;
  logic [7:0]        val_q;
  // divide: numerator < 2^24, divisor span < 2^16
  logic [24:0]       num_q;
  logic [15:0]       span_q;
  logic [4:0]        step_q;
  logic [7:0]        quo_q;
  logic [23:0]       out_q;
  logic              ovalid_q;

  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [23:0]       ram_wdata, ram_rdata;

  scms_ram #(.Width(24), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // pixel offsets, signed, and their magnitudes
  logic signed [CW:0] dx, dy;
  logic [16:0]        d2_now;
  logic [CW-1:0]      adx, ady;
  assign dx  = $signed({2'b00, x_q}) - $signed({2'b00, cx_q});
  assign dy  = $signed({2'b00, y_q}) - $signed({2'b00, cy_q});
  assign adx = dx[CW] ? CW'(-dx) : CW'(dx);
  assign ady = dy[CW] ? CW'(-dy) : CW'(dy);
  // offsets never exceed 255 within the box, so squares fit 16 bits each
  assign d2_now = 17'(16'(adx[7:0]) * 16'(adx[7:0])) + 17'(16'(ady[7:0]) * 16'(ady[7:0]));

  logic [15:0] r2;
  assign r2 = 16'(outer_q) * 16'(outer_q);

  // one sqrt step
  logic [33:0] trial;
  assign trial = rem_q - (root_q + sbit_q);

  // final root fits 17 bits
  logic [16:0] rt;
  assign rt = root_q[16:0];

  logic [16:0] hard8, outer8;
  assign hard8  = {1'b0, hard_q, 8'd0};
  assign outer8 = {1'b0, outer_q, 8'd0};

  logic [24:0] div_sh;
  assign div_sh = {9'd0, span_q} << step_q;

  logic [7:0] old_ch;
  always_comb begin
    case (ch_q)
      CH_GREEN: old_ch = ram_rdata[15:8];
      CH_BLUE:  old_ch = ram_rdata[23:16];
      default:  old_ch = ram_rdata[7:0];
    endcase
  end

  logic [23:0] merged;
  always_comb begin
    merged = ram_rdata;
    case (ch_q)
      CH_GREEN: merged[15:8]  = val_q;
      CH_BLUE:  merged[23:16] = val_q;
      default:  merged[7:0]   = val_q;
    endcase
  end

  // box bounds from saturated centre
  logic [CoordW-1:0] scx, scy;
  logic [7:0]        sh, so;
  logic [BW-1:0]     lo_x, lo_y, hi_x, hi_y;
  always_comb begin
    scx  = (CW'(f_cx) > CW'(MaskSize - 1)) ? CoordW'(MaskSize - 1) : CoordW'(f_cx);
    scy  = (CW'(f_cy) > CW'(MaskSize - 1)) ? CoordW'(MaskSize - 1) : CoordW'(f_cy);
    sh   = (f_hard == 8'd0) ? 8'd1 : f_hard;
    so   = (f_outer == 8'd0) ? 8'd1 : f_outer;
    lo_x = (BW'(scx) > BW'(so)) ? BW'(scx) - BW'(so) : '0;
    lo_y = (BW'(scy) > BW'(so)) ? BW'(scy) - BW'(so) : '0;
    hi_x = BW'(scx) + BW'(so);
    hi_y = BW'(scy) + BW'(so);
    if (hi_x > BW'(MaskSize - 1)) hi_x = BW'(MaskSize - 1);
    if (hi_y > BW'(MaskSize - 1)) hi_y = BW'(MaskSize - 1);
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = merged;
    ram_addr  = {y_q, x_q};
    if (state_q == ST_INIT || state_q == ST_CLEAR) begin
      ram_we    = !cnt_q[AddrW];
      ram_wdata = '0;
      ram_addr  = cnt_q[AddrW-1:0];
    end else if (state_q == ST_WR) begin
      ram_we = (val_q > old_ch);
    end
  end

  logic last_px;
  assign last_px = (x_q == x1_q) && (y_q == y1_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (cnt_q[AddrW]) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (f_req)
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_STAMP: state_d = (f_ch == CH_NONE) ? ST_OUT : ST_PIX;
            REQ_READ:  state_d = ST_READ;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_CLEAR: if (cnt_q[AddrW]) state_d = ST_OUT;
      ST_PIX:   state_d = (d2_now > {1'b0, r2}) ? (last_px ? ST_OUT : ST_PIX) : ST_RD;
      ST_RD:    state_d = (outer_q <= hard_q) ? ST_WR : ST_SQRT;
      ST_SQRT:  if (sbit_q == '0) state_d = ST_EVAL;
      ST_EVAL: begin
        if (rt <= hard8 || rt >= outer8) state_d = ST_WR;
        else state_d = ST_DIV;
      end
      ST_DIV:   if (step_q == 5'd0) state_d = ST_WR;
      ST_WR:    state_d = last_px ? ST_OUT : ST_PIX;
      ST_READ:  state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_CLEAR) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cx_q    <= scx;
        cy_q    <= scy;
        hard_q  <= sh;
        outer_q <= so;
        ch_q    <= f_ch;
        x0_q    <= CoordW'(lo_x);
        x_q     <= CoordW'(lo_x);
        y_q     <= CoordW'(lo_y);
        x1_q    <= CoordW'(hi_x);
        y1_q    <= CoordW'(hi_y);
        rd_ok_q <= (CW'(f_rx) < CW'(MaskSize)) && (CW'(f_ry) < CW'(MaskSize));
        if (f_req == REQ_READ) begin
          x_q <= CoordW'(f_rx);
          y_q <= CoordW'(f_ry);
        end
        d2_q <= '0;
      end
      ST_PIX: begin
        // d2 of the pixel now addressed
        d2_q <= d2_now;
        if (d2_now > {1'b0, r2}) begin
          if (x_q == x1_q) begin
            x_q <= x0_q;
            y_q <= y_q + 1'b1;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
      end
      ST_RD: begin
        rem_q  <= {1'b0, d2_q, 16'd0};
        root_q <= '0;
        sbit_q <= 34'd1 << 32;
        val_q  <= 8'd255;
      end
      ST_SQRT: begin
        if (sbit_q != '0) begin
          if (rem_q >= root_q + sbit_q) begin
            rem_q  <= trial;
            root_q <= (root_q >> 1) + sbit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_EVAL: begin
        if (rt <= hard8) val_q <= 8'd255;
        else if (rt >= outer8) val_q <= 8'd0;
        span_q <= {outer_q - hard_q, 8'd0};
        num_q  <= 25'(({8'd0, outer8} - {8'd0, rt}) * 25'd255)
                  + 25'({outer_q - hard_q, 7'd0});
        step_q <= 5'd8;
        quo_q  <= '0;
      end
      ST_DIV: begin
        // restoring divide, quotient < 256
        if (num_q >= div_sh) begin
          num_q <= num_q - div_sh;
          quo_q <= quo_q | 8'(9'd1 << step_q);
          if (step_q == 5'd0) val_q <= quo_q | 8'(9'd1 << step_q);
        end else if (step_q == 5'd0) begin
          val_q <= quo_q;
        end
        if (step_q != 5'd0) step_q <= step_q - 1'b1;
      end
      ST_WR: begin
        if (x_q == x1_q) begin
          x_q <= x0_q;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      ST_OUT: begin
        // only a read inside the mask returns pixel data
        out_q <= (rd_ok_q && f_read_q) ? ram_rdata : '0;
      end
      ST_READ: begin
        ch_q <= CH_RED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) f_read_q <= (f_req == REQ_READ);
  end
endmodule
`default_nettype wire

// File: src/scms_ram.sv
// ----------------------------------------------------------------------------
// scms_ram: generic single-port ram
// one access per cycle, a write also reading the old word; registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module scms_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the soft circle mask stamper core
// drives clear, stamp, read and unknown requests over the request stream,
// predicts the mask contents and read results, checks each result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import scms_pkg::*;

  localparam int unsigned Side = MaskSizeDefault;
  localparam int NumRandom = 560;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // req_type
  logic [1:0]  s_axis_tuser;
  // center_x, center_y, hard_radius, outer_radius, channel, read_x, read_y
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // pixel_red, pixel_green, pixel_blue
  logic [23:0] m_axis_tdata;

  soft_circle_mask_stamper_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  typedef struct packed {
    req_type_e req;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] hard;
    logic [7:0] outer;
    channel_e   ch;
    logic [7:0] rx;
    logic [7:0] ry;
  } mask_req_t;

  typedef struct {
    mask_req_t   r;
    bit          fixed;    // expected pixel typed in below
    logic [23:0] pixel;
  } directed_row_t;

  // predicted mask contents, red in 7:0, green 15:8, blue 23:16
  logic [23:0] mask_shadow [Side*Side];
  logic [23:0] pixel_q [$];
  int          n_errors;
  int          sender_idle_pct;
  int          recv_stall_pct;
  bit          hold_go;

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 8.8 fixed point falloff, round half up
  function automatic logic [7:0] falloff(longint unsigned d2, longint unsigned h,
                                         longint unsigned o);
    longint unsigned rad;
    longint unsigned span;
    if (o <= h) return 8'd255;
    rad = int_sqrt(d2 << 16);
    if (rad <= (h << 8)) return 8'd255;
    if (rad >= (o << 8)) return 8'd0;
    span = (o - h) << 8;
    return 8'((((o << 8) - rad) * 255 + span / 2) / span);
  endfunction

  function automatic void stamp_shadow(mask_req_t r);
    int x0, x1, y0, y1, cx, cy, h, o, dx, dy, sh;
    logic [7:0] v;
    if (r.ch == CH_NONE) return;
    h  = (r.hard == 0) ? 1 : r.hard;
    o  = (r.outer == 0) ? 1 : r.outer;
    cx = (r.cx > Side - 1) ? Side - 1 : r.cx;
    cy = (r.cy > Side - 1) ? Side - 1 : r.cy;
    sh = int'(r.ch) * 8;
    x0 = (cx - o < 0) ? 0 : cx - o;
    y0 = (cy - o < 0) ? 0 : cy - o;
    x1 = (cx + o > Side - 1) ? Side - 1 : cx + o;
    y1 = (cy + o > Side - 1) ? Side - 1 : cy + o;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        dx = x - cx;
        dy = y - cy;
        if (dx * dx + dy * dy <= o * o) begin
          v = falloff(dx * dx + dy * dy, h, o);
          if (v > mask_shadow[y * Side + x][sh +: 8])
            mask_shadow[y * Side + x][sh +: 8] = v;
        end
      end
    end
  endfunction

  // applies one request to the shadow mask and returns the pixel it reads
  function automatic logic [23:0] predict_pixel(mask_req_t r);
    logic [23:0] px;
    px = '0;
    case (r.req)
      REQ_CLEAR: foreach (mask_shadow[i]) mask_shadow[i] = '0;
      REQ_STAMP: stamp_shadow(r);
      REQ_READ: begin
        if (r.rx < Side && r.ry < Side) px = mask_shadow[r.ry * Side + r.rx];
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [55:0] pack_req(mask_req_t r);
    return {6'd0, r.ry, r.rx, r.ch, r.outer, r.hard, r.cy, r.cx};
  endfunction

  function automatic mask_req_t mk(req_type_e q, int cx, int cy, int h, int o, channel_e c,
                                   int rx, int ry);
    mask_req_t r;
    r.req = q; r.cx = cx; r.cy = cy; r.hard = h; r.outer = o; r.ch = c;
    r.rx = rx; r.ry = ry;
    return r;
  endfunction

  // mostly reads near recent stamps, small stamps, rare clears
  function automatic mask_req_t random_req(int lx, int ly);
    mask_req_t r;
    int k;
    int o;
    r = mask_req_t'($bits(mask_req_t)'({$urandom, $urandom}));
    k = $urandom_range(0, 99);
    if (k < 1) begin
      r.req = REQ_CLEAR;
    end else if (k < 5) begin
      r.req = REQ_NONE;
    end else if (k < 38) begin
      r.req = REQ_STAMP;
      if ($urandom_range(0, 9) == 0) o = $urandom_range(5, 12);
      else o = $urandom_range(0, 4);
      r.outer = 8'(o);
      r.hard  = 8'($urandom_range(0, o + 1));
      r.ch    = channel_e'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        r.cx = lx + $urandom_range(0, 6) - 3;
        r.cy = ly + $urandom_range(0, 6) - 3;
      end
    end else begin
      r.req = REQ_READ;
      if ($urandom_range(0, 4) != 0) begin
        r.rx = lx + $urandom_range(0, 12) - 6;
        r.ry = ly + $urandom_range(0, 12) - 6;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- receiver
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        logic [23:0] want;
        want = pixel_q.pop_front();
        if (m_axis_tdata[7:0] !== want[7:0]) begin
          $display("%0t: pixel_red expected %0d actual %0d", $time, want[7:0],
                   m_axis_tdata[7:0]);
          n_errors++;
        end
        if (m_axis_tdata[15:8] !== want[15:8]) begin
          $display("%0t: pixel_green expected %0d actual %0d", $time, want[15:8],
                   m_axis_tdata[15:8]);
          n_errors++;
        end
        if (m_axis_tdata[23:16] !== want[23:16]) begin
          $display("%0t: pixel_blue expected %0d actual %0d", $time, want[23:16],
                   m_axis_tdata[23:16]);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_req(mask_req_t r, bit fixed, logic [23:0] pixel);
    logic [23:0] px;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req;
    s_axis_tdata  <= pack_req(r);
    do @(posedge clk_i); while (!(s_axis_tready === 1'b1));
    // accepted at this edge
    px = predict_pixel(r);
    pixel_q.push_back(fixed ? pixel : px);
    if (fixed && px !== pixel) begin
      $display("%0t: directed row mismatch, expected %h actual %h", $time, pixel, px);
      n_errors++;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  directed_row_t dir_tab [$];

  initial begin
    mask_req_t r;
    int lx, ly;
    n_errors        = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_go         = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tuser    = '0;
    s_axis_tdata    = '0;
    foreach (mask_shadow[i]) mask_shadow[i] = '0;

    // reads after reset, unknown request, zero radii, edge centers,
    // unknown channel, full-size stamp, hard beyond outer, clear
    dir_tab = '{
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 255, 255), 1, 24'h0},
      '{mk(REQ_NONE,  255, 255, 255, 255, CH_NONE, 255, 255), 1, 24'h0},
      '{mk(REQ_STAMP, 10, 10, 0, 0, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 10, 10), 1, 24'h0000ff},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 11, 10), 0, 24'h0},
      '{mk(REQ_STAMP, 255, 0, 3, 10, CH_GREEN, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 250, 2), 0, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 247, 4), 0, 24'h0},
      '{mk(REQ_STAMP, 128, 128, 5, 5, CH_NONE, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 128, 128), 1, 24'h0},
      '{mk(REQ_STAMP, 0, 0, 255, 255, CH_BLUE, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 200, 100), 0, 24'h0},
      '{mk(REQ_STAMP, 100, 100, 9, 4, CH_GREEN, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 102, 101), 0, 24'h0},
      '{mk(REQ_CLEAR, 0, 0, 0, 0, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_STAMP, 255, 255, 1, 6, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_STAMP, 253, 254, 2, 5, CH_RED, 0, 0), 1, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 252, 253), 0, 24'h0},
      '{mk(REQ_READ,  0, 0, 0, 0, CH_RED, 255, 255), 0, 24'h0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].r, dir_tab[i].fixed, dir_tab[i].pixel);

    lx = 128;
    ly = 128;
    for (int n = 0; n < NumRandom; n++) begin
      // four idling phases
      if (n % (NumRandom / 4) == 0) begin
        drain_results();
        case (n / (NumRandom / 4))
          0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
          default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
        endcase
      end
      // long receiver hold-off while requests keep coming
      if (n == 20) hold_go = 1'b1;
      r = random_req(lx, ly);
      if (r.req == REQ_STAMP) begin
        lx = r.cx;
        ly = r.cy;
      end
      send_req(r, 1'b0, 24'h0);
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) $display("** soft_circle_mask_stamper_core: PASSED **");
    else $display("** soft_circle_mask_stamper_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- limit
  initial begin
    #400_000_000;
    $display("** soft_circle_mask_stamper_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
